// ===== src/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

    // Payload widths
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    // Largest capacity the register can hold; no more cells are ever used
    localparam int CAP_LIMIT = (2 ** CAP_W) - 1;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CAP_RESET     = 16;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [MODE_W-1:0]        mode_t;
    typedef logic [STATUS_W-1:0]      status_t;
    typedef logic [CAP_W-1:0]         cap_t;
    typedef logic [REG_IDX_W-1:0]     reg_idx_t;

    localparam reg_idx_t REG_CAPACITY = reg_idx_t'(0);

    localparam mode_t MODE_PUSH_FRONT = 2'd0;
    localparam mode_t MODE_PUSH_BACK  = 2'd1;
    localparam mode_t MODE_POP_FRONT  = 2'd2;
    localparam mode_t MODE_POP_BACK   = 2'd3;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_OVERFLOW  = 2'd1;
    localparam status_t STATUS_UNDERFLOW = 2'd2;

    localparam word_t EMPTY_WORD = -32'sd1;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK,
        CELL_CLEAR
    } cell_cmd_t;

    // Configuration block to control
    typedef struct packed {
        logic clear;
        cap_t eff_cap;
    } cbd_cfg_t;

endpackage

`default_nettype wire

// ===== src/cbd_if.sv =====
`default_nettype none

interface cbd_in_if
    import cbd_pkg::*;
();
    logic  valid;
    logic  ready;
    mode_t mode;
    word_t value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface cbd_out_if
    import cbd_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    word_t   popped_value;
    word_t   front_value;
    word_t   back_value;
    logic    is_empty;
    logic    is_full;

    modport source (
        output valid, output status, output popped_value, output front_value,
        output back_value, output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input status, input popped_value, input front_value,
        input back_value, input is_empty, input is_full, output ready
    );
endinterface

`default_nettype wire

// ===== src/circular_buffer_deque.sv =====
`default_nettype none
// Double-ended queue of signed 32-bit words.
// in_bus (valid/ready) carries one command beat: mode selects push front,
// push back, pop front or pop back; value is the word to push.
// out_bus (valid/ready) returns one result beat per command: status,
// popped word, front and back words after the command (-1 when empty),
// and the empty and full flags.
// The entries sit in a row of cells, front in cell 0; a successful push or
// pop front shifts the row by one cell, a push back fills the first free
// cell and a pop back frees the last occupied one. Each result beat comes in
// the cycle after its command; one command per cycle while out_bus is ready.
// The capacity register (APB, address 0) limits the entries held; writing
// it empties the deque. Write it only while no command is in flight.
// Reset empties the deque and sets capacity to 16.
// When out_bus stalls, the result is held and in_bus ready drops until the
// held result is taken; commands are not lost.
module circular_buffer_deque
    import cbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    cbd_in_if.sink              in_bus,
    cbd_out_if.source           out_bus,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [PADDR_W-1:0]   paddr,
    input  wire [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int NCELL = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;

    cbd_cfg_t  cfg;
    cell_cmd_t cmd;

    logic [NCELL-1:0] cell_valid;
    word_t            cell_data [NCELL];

    cap_t    count_reg;
    cap_t    count_next;
    word_t   back_reg;
    word_t   back_next;
    word_t   front_next;
    word_t   popped_next;
    word_t   second_last;
    status_t status_next;

    logic    out_valid_reg;
    status_t status_reg;
    word_t   popped_reg;
    word_t   front_reg;
    word_t   back_out_reg;
    logic    empty_reg;
    logic    full_reg;

    logic    accept;
    logic    empty_now;
    logic    full_now;
    logic    empty_after;

    cbd_cfg #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Row of cells, front at index 0
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic  lv;
        word_t ld;
        logic  rv;
        word_t rd;
        if (i == 0)
        begin : g_first
            assign lv = 1'b1;
            assign ld = in_bus.value;
        end
        else
        begin : g_mid_l
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
        end
        if (i == NCELL - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
        end
        else
        begin : g_mid_r
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
        end
        cbd_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .push_value  (in_bus.value),
            .valid       (cell_valid[i]),
            .data        (cell_data[i])
        );
    end

    assign in_bus.ready = !out_valid_reg || out_bus.ready;
    assign accept       = in_bus.valid && in_bus.ready;
    assign empty_now    = (count_reg == '0);
    assign full_now     = (count_reg >= cfg.eff_cap);

    // Entry just ahead of the back: the valid cell followed by exactly one valid cell
    always_comb
    begin
        second_last = '0;
        for (int i = 0; i < NCELL - 1; i++)
        begin
            if (cell_valid[i+1] && ((i + 2 >= NCELL) || !cell_valid[(i + 2) % NCELL]))
            begin
                second_last = second_last | cell_data[i];
            end
        end
    end

    // Command decode and result of the step
    always_comb
    begin
        cmd         = CELL_HOLD;
        status_next = STATUS_OK;
        count_next  = count_reg;
        popped_next = '0;
        front_next  = cell_data[0];
        back_next   = back_reg;
        if (cfg.clear)
        begin
            cmd        = CELL_CLEAR;
            count_next = '0;
        end
        else if (accept)
        begin
            unique case (in_bus.mode)
                MODE_PUSH_FRONT:
                begin
                    if (full_now)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        cmd        = CELL_PUSH_FRONT;
                        count_next = count_reg + cap_t'(1);
                        front_next = in_bus.value;
                        back_next  = empty_now ? in_bus.value : back_reg;
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (full_now)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        cmd        = CELL_PUSH_BACK;
                        count_next = count_reg + cap_t'(1);
                        front_next = empty_now ? in_bus.value : cell_data[0];
                        back_next  = in_bus.value;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty_now)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        cmd         = CELL_POP_FRONT;
                        count_next  = count_reg - cap_t'(1);
                        popped_next = cell_data[0];
                        front_next  = cell_data[1];
                    end
                end
                MODE_POP_BACK:
                begin
                    if (empty_now)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        cmd         = CELL_POP_BACK;
                        count_next  = count_reg - cap_t'(1);
                        popped_next = back_reg;
                        back_next   = second_last;
                    end
                end
                default:
                begin
                    cmd = CELL_HOLD;
                end
            endcase
        end
    end

    assign empty_after = (count_next == '0);

    // Deque bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        back_reg <= back_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_bus.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            popped_reg   <= popped_next;
            front_reg    <= empty_after ? EMPTY_WORD : front_next;
            back_out_reg <= empty_after ? EMPTY_WORD : back_next;
            empty_reg    <= empty_after;
            full_reg     <= (count_next >= cfg.eff_cap);
        end
    end

    assign out_bus.valid        = out_valid_reg;
    assign out_bus.status       = status_reg;
    assign out_bus.popped_value = popped_reg;
    assign out_bus.front_value  = front_reg;
    assign out_bus.back_value   = back_out_reg;
    assign out_bus.is_empty     = empty_reg;
    assign out_bus.is_full      = full_reg;

    // Checks
    a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupied cells disagree with entry count");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfg.eff_cap)
        else $error("entry count above capacity");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> (count_reg == '0))
        else $error("capacity write did not empty the deque");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_bus.valid && out_bus.status == STATUS_OVERFLOW) |-> out_bus.is_full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_bus.valid && out_bus.status == STATUS_UNDERFLOW) |-> out_bus.is_empty)
        else $error("underflow reported while not empty");

endmodule

`default_nettype wire

// ===== src/cbd_cell.sv =====
`default_nettype none

module cbd_cell
    import cbd_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  cell_cmd_t  cmd,
    input  wire        left_valid,
    input  word_t      left_data,
    input  wire        right_valid,
    input  word_t      right_data,
    input  word_t      push_value,
    output logic       valid,
    output word_t      data
);

    logic  valid_reg;
    logic  valid_next;
    word_t data_reg;
    word_t data_next;

    // Hold, shift back or front, fill first free cell, free last cell, or clear
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (cmd)
            CELL_HOLD:
            begin
                valid_next = valid_reg;
            end
            CELL_PUSH_FRONT:
            begin
                valid_next = left_valid;
                data_next  = left_data;
            end
            CELL_PUSH_BACK:
            begin
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    data_next  = push_value;
                end
            end
            CELL_POP_FRONT:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            CELL_POP_BACK:
            begin
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// ===== src/cbd_cfg.sv =====
`default_nettype none

module cbd_cfg
    import cbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [PADDR_W-1:0]   paddr,
    input  wire [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output cbd_cfg_t            cfg
);

    localparam int   CAP_MAX  = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
    localparam cap_t CapMax   = cap_t'(CAP_MAX);
    localparam cap_t CapOne   = cap_t'(1);

    cap_t     capacity_reg;
    cap_t     capacity_next;
    reg_idx_t reg_idx;
    logic     wr_cap;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_cap  = psel && penable && pwrite && (reg_idx == REG_CAPACITY);

    // Capacity register
    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_cap)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cap_t'(CAP_RESET);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_CAPACITY)
        begin
            prdata = {{(PDATA_W-CAP_W){1'b0}}, capacity_reg};
        end
    end

    // Zero acts as one, anything above the cell count saturates
    always_comb
    begin
        cfg.clear = wr_cap;
        if (capacity_reg == '0)
        begin
            cfg.eff_cap = CapOne;
        end
        else if (capacity_reg > CapMax)
        begin
            cfg.eff_cap = CapMax;
        end
        else
        begin
            cfg.eff_cap = capacity_reg;
        end
    end

endmodule

`default_nettype wire
